>>> hw/rtl/fpmm_pkg.sv
// shared types and constants for the single precision matrix multiplier
package fpmm_pkg;

    localparam int MAX_DIM_DEFAULT = 64;
    localparam int CFG_WIDTH       = 7;
    localparam int IDX_WIDTH       = 6;
    localparam int PADDR_WIDTH     = 4;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_READ_C  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_ROWS  = 2'd0,
        REG_COLS  = 2'd1,
        REG_DEPTH = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_MAC,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_MUL,
        MS_MLZ,
        MS_MRND,
        MS_ALIGN,
        MS_ALZ,
        MS_ARND
    } mac_step_t;

    typedef struct packed {
        logic clear;
        logic start;
    } mac_ctl_t;

endpackage

>>> hw/rtl/fpmm_ifs.sv
// valid/ready channel interfaces for command words and result words
interface fpmm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [5:0]  row_index;
    logic [5:0]  col_index;
    logic [31:0] element_bits;

    modport source (output valid, output operation, output row_index, output col_index,
                    output element_bits, input ready);
    modport sink (input valid, input operation, input row_index, input col_index,
                  input element_bits, output ready);
endinterface

interface fpmm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] product_bits;
    logic        out_of_range;

    modport source (output valid, output product_bits, output out_of_range, input ready);
    modport sink (input valid, input product_bits, input out_of_range, output ready);
endinterface

>>> hw/rtl/fpmm_mac.sv
// shared single precision multiply then add unit with accumulator
module fpmm_mac
    import fpmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mac_ctl_t    ctl,
    input  logic [31:0] a_bits,
    input  logic [31:0] b_bits,
    output logic        done,
    output logic [31:0] acc_bits
);

    mac_step_t step_reg, step_next;

    logic [31:0] a_reg, b_reg, p_reg, acc_reg;
    logic [47:0] prod_reg;
    logic [47:0] prod_reg_sh;
    logic signed [10:0] pexp_reg, aexp_reg;
    logic [5:0]  plz_reg;
    logic        psign_reg, pnan_reg, pinf_reg, pzero_reg;
    logic [27:0] sum_reg;
    logic [4:0]  alz_reg;
    logic        asign_reg, zsign_reg, anan_reg, ainf_reg;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) n = 5'(27 - i);
        end
        return n;
    endfunction

    // sig has its leading one at bit 27, e is the biased exponent of that bit
    function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                               input logic [27:0] sig);
        logic [59:0] wide;
        logic [10:0] amt;
        logic [4:0]  amt_sat;
        logic [27:0] sh;
        logic        lost, g, st, inc, subn;
        logic [24:0] rnd;
        logic signed [10:0] eo;
        logic [22:0] mo;
        subn = (e < 11'sd1);
        amt = 11'(11'sd1 - e);
        amt_sat = (amt > 11'd31) ? 5'd31 : amt[4:0];
        wide = {sig, 32'b0} >> amt_sat;
        if (subn) begin
            sh = wide[59:32];
            lost = |wide[31:0];
        end else begin
            sh = sig;
            lost = 1'b0;
        end
        g = sh[3];
        st = (|sh[2:0]) | lost;
        inc = g & (st | sh[4]);
        rnd = {1'b0, sh[27:4]} + {24'b0, inc};
        if (subn) begin
            eo = rnd[23] ? 11'sd1 : 11'sd0;
            mo = rnd[22:0];
        end else if (rnd[24]) begin
            eo = e + 11'sd1;
            mo = 23'b0;
        end else begin
            eo = e;
            mo = rnd[22:0];
        end
        if (eo >= 11'sd255) return {s, 8'hFF, 23'b0};
        return {s, eo[7:0], mo};
    endfunction

    // multiply stage decode
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    always_comb
    begin
        ea = a_reg[30:23];
        eb = b_reg[30:23];
        ma = {ea != 8'd0, a_reg[22:0]};
        mb = {eb != 8'd0, b_reg[22:0]};
        a_nan = (ea == 8'hFF) && (a_reg[22:0] != 23'd0);
        b_nan = (eb == 8'hFF) && (b_reg[22:0] != 23'd0);
        a_inf = (ea == 8'hFF) && (a_reg[22:0] == 23'd0);
        b_inf = (eb == 8'hFF) && (b_reg[22:0] == 23'd0);
        a_zero = (ea == 8'd0) && (a_reg[22:0] == 23'd0);
        b_zero = (eb == 8'd0) && (b_reg[22:0] == 23'd0);
    end

    // add stage decode and alignment
    logic [7:0]  ex, ey, ebig, esml;
    logic        x_nan, y_nan, x_inf, y_inf, x_big;
    logic [23:0] mbig, msml;
    logic [7:0]  dexp;
    logic [4:0]  dsat;
    logic [57:0] yfull;
    logic [26:0] y_al;
    logic [27:0] sum_w;
    logic        sbig, ssml;

    always_comb
    begin
        ex = acc_reg[30:23];
        ey = p_reg[30:23];
        x_nan = (ex == 8'hFF) && (acc_reg[22:0] != 23'd0);
        y_nan = (ey == 8'hFF) && (p_reg[22:0] != 23'd0);
        x_inf = (ex == 8'hFF) && (acc_reg[22:0] == 23'd0);
        y_inf = (ey == 8'hFF) && (p_reg[22:0] == 23'd0);
        x_big = acc_reg[30:0] >= p_reg[30:0];
        if (x_big) begin
            ebig = (ex == 8'd0) ? 8'd1 : ex;
            esml = (ey == 8'd0) ? 8'd1 : ey;
            mbig = {ex != 8'd0, acc_reg[22:0]};
            msml = {ey != 8'd0, p_reg[22:0]};
            sbig = acc_reg[31];
            ssml = p_reg[31];
        end else begin
            ebig = (ey == 8'd0) ? 8'd1 : ey;
            esml = (ex == 8'd0) ? 8'd1 : ex;
            mbig = {ey != 8'd0, p_reg[22:0]};
            msml = {ex != 8'd0, acc_reg[22:0]};
            sbig = p_reg[31];
            ssml = acc_reg[31];
        end
        dexp = ebig - esml;
        dsat = (dexp > 8'd31) ? 5'd31 : dexp[4:0];
        yfull = {msml, 3'b0, 31'b0} >> dsat;
        y_al = {yfull[57:32], yfull[31] | (|yfull[30:0])};
        if (sbig == ssml) sum_w = {1'b0, mbig, 3'b0} + {1'b0, y_al};
        else sum_w = {1'b0, mbig, 3'b0} - {1'b0, y_al};
    end

    always_comb
    begin
        step_next = step_reg;
        unique case (step_reg)
            MS_IDLE:  if (ctl.start) step_next = MS_MUL;
            MS_MUL:   step_next = MS_MLZ;
            MS_MLZ:   step_next = MS_MRND;
            MS_MRND:  step_next = MS_ALIGN;
            MS_ALIGN: step_next = MS_ALZ;
            MS_ALZ:   step_next = MS_ARND;
            MS_ARND:  step_next = MS_IDLE;
            default:  step_next = MS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) step_reg <= MS_IDLE;
        else step_reg <= step_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.clear) acc_reg <= 32'd0;
        unique case (step_reg)
            MS_IDLE:
            begin
                if (ctl.start)
                begin
                    a_reg <= a_bits;
                    b_reg <= b_bits;
                end
            end
            MS_MUL:
            begin
                prod_reg <= ma * mb;
                pexp_reg <= 11'(signed'({3'b0, (ea == 8'd0) ? 8'd1 : ea}))
                          + 11'(signed'({3'b0, (eb == 8'd0) ? 8'd1 : eb})) - 11'sd126;
                psign_reg <= a_reg[31] ^ b_reg[31];
                pnan_reg <= a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
                pinf_reg <= a_inf | b_inf;
                pzero_reg <= a_zero | b_zero;
            end
            MS_MLZ: plz_reg <= lzc48(prod_reg);
            MS_MRND:
            begin
                priority if (pnan_reg) p_reg <= CANON_NAN;
                else if (pinf_reg) p_reg <= {psign_reg, 8'hFF, 23'b0};
                else if (pzero_reg) p_reg <= {psign_reg, 31'b0};
                else
                begin
                    p_reg <= round_pack(psign_reg, pexp_reg - 11'(signed'({5'b0, plz_reg})),
                                        {prod_reg_sh[47:21], |prod_reg_sh[20:0]});
                end
            end
            MS_ALIGN:
            begin
                sum_reg <= sum_w;
                aexp_reg <= 11'(signed'({3'b0, ebig}));
                asign_reg <= x_inf ? acc_reg[31] : (y_inf ? p_reg[31] : sbig);
                zsign_reg <= acc_reg[31] & p_reg[31];
                anan_reg <= x_nan | y_nan | (x_inf & y_inf & (acc_reg[31] != p_reg[31]));
                ainf_reg <= x_inf | y_inf;
            end
            MS_ALZ: alz_reg <= lzc28(sum_reg);
            MS_ARND:
            begin
                priority if (anan_reg) acc_reg <= CANON_NAN;
                else if (ainf_reg) acc_reg <= {asign_reg, 8'hFF, 23'b0};
                else if (sum_reg == 28'd0) acc_reg <= {zsign_reg, 31'b0};
                else
                begin
                    acc_reg <= round_pack(asign_reg,
                                          aexp_reg + 11'sd1 - 11'(signed'({6'b0, alz_reg})),
                                          sum_reg << alz_reg);
                end
            end
            default: ;
        endcase
    end

    assign prod_reg_sh = prod_reg << plz_reg;

    assign done = (step_reg == MS_ARND);
    assign acc_bits = acc_reg;

endmodule

>>> hw/rtl/fp32_matrix_multiply_top.sv
// single precision matrix multiplier top level: element stores, sequencer, apb registers
//
// Write words store one element of A (row, inner) or B (inner, column). A read word walks
// the inner dimension through one shared multiply-add unit; each inner step is a store read,
// an operand load and six multiply/round/add/round steps. The block takes no new word until
// the read finishes.
// Sizes above MAX_DIM act as MAX_DIM; out-of-range words give out_of_range with zero data.
// Element stores are not cleared: read only entries that were written. NaN results come
// out as 0x7FC00000.
module fp32_matrix_multiply_top
    import fpmm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    fpmm_in_if.sink                in_ch,
    fpmm_out_if.source             out_ch,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW = $clog2(DEPTH);
    localparam int KW = $clog2(MAX_DIM + 1);
    localparam int SW = (KW > CFG_WIDTH) ? KW : CFG_WIDTH;

    logic [CFG_WIDTH-1:0] rows_reg, cols_reg, depth_reg;
    logic [SW-1:0] m_eff, n_eff, k_eff;

    state_t state_reg, state_next;
    logic [IDX_WIDTH-1:0] row_reg, row_next, col_reg, col_next;
    logic [KW-1:0] k_reg, k_next;
    logic oor_reg, oor_next;
    logic out_valid_reg, out_valid_next;
    logic [31:0] out_bits_reg, out_bits_next;
    logic out_oor_reg, out_oor_next;

    logic a_we, b_we;
    logic [AW-1:0] waddr, a_raddr, b_raddr;
    logic [31:0] a_mem [DEPTH];
    logic [31:0] b_mem [DEPTH];
    logic [31:0] a_rd_reg, b_rd_reg;

    mac_ctl_t mac_ctl;
    logic mac_done;
    logic [31:0] acc_bits;

    logic accept, row_lt_m, row_lt_k, col_lt_k, col_lt_n, cfg_we;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_WIDTH'(64);
            cols_reg <= CFG_WIDTH'(64);
            depth_reg <= CFG_WIDTH'(64);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_ROWS:  rows_reg <= pwdata[CFG_WIDTH-1:0];
                REG_COLS:  cols_reg <= pwdata[CFG_WIDTH-1:0];
                REG_DEPTH: depth_reg <= pwdata[CFG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_ROWS:  prdata = {{(32 - CFG_WIDTH){1'b0}}, rows_reg};
            REG_COLS:  prdata = {{(32 - CFG_WIDTH){1'b0}}, cols_reg};
            REG_DEPTH: prdata = {{(32 - CFG_WIDTH){1'b0}}, depth_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign m_eff = (SW'(rows_reg) > SW'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(rows_reg);
    assign n_eff = (SW'(cols_reg) > SW'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(cols_reg);
    assign k_eff = (SW'(depth_reg) > SW'(MAX_DIM)) ? SW'(MAX_DIM) : SW'(depth_reg);

    // element stores
    assign row_lt_m = SW'(in_ch.row_index) < m_eff;
    assign row_lt_k = SW'(in_ch.row_index) < k_eff;
    assign col_lt_k = SW'(in_ch.col_index) < k_eff;
    assign col_lt_n = SW'(in_ch.col_index) < n_eff;

    assign waddr = AW'(AW'(in_ch.row_index) * AW'(MAX_DIM) + AW'(in_ch.col_index));
    assign a_raddr = AW'(AW'(row_reg) * AW'(MAX_DIM) + AW'(k_reg));
    assign b_raddr = AW'(AW'(k_reg) * AW'(MAX_DIM) + AW'(col_reg));

    always_ff @(posedge clk)
    begin
        if (a_we) a_mem[waddr] <= in_ch.element_bits;
        a_rd_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we) b_mem[waddr] <= in_ch.element_bits;
        b_rd_reg <= b_mem[b_raddr];
    end

    fpmm_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mac_ctl),
        .a_bits   (a_rd_reg),
        .b_bits   (b_rd_reg),
        .done     (mac_done),
        .acc_bits (acc_bits)
    );

    // sequencer
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept = in_ch.valid & in_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        row_next = row_reg;
        col_next = col_reg;
        k_next = k_reg;
        oor_next = oor_reg;
        out_valid_next = out_valid_reg & ~out_ch.ready;
        out_bits_next = out_bits_reg;
        out_oor_next = out_oor_reg;
        a_we = 1'b0;
        b_we = 1'b0;
        mac_ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    row_next = in_ch.row_index;
                    col_next = in_ch.col_index;
                    k_next = '0;
                    oor_next = 1'b1;
                    unique case (in_ch.operation)
                        OP_WRITE_A:
                        begin
                            if (row_lt_m && col_lt_k) a_we = 1'b1;
                            else state_next = ST_EMIT;
                        end
                        OP_WRITE_B:
                        begin
                            if (row_lt_k && col_lt_n) b_we = 1'b1;
                            else state_next = ST_EMIT;
                        end
                        OP_READ_C:
                        begin
                            if (row_lt_m && col_lt_n)
                            begin
                                oor_next = 1'b0;
                                mac_ctl.clear = 1'b1;
                                state_next = (k_eff == '0) ? ST_EMIT : ST_FETCH;
                            end
                            else state_next = ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: state_next = ST_LOAD;
            ST_LOAD:
            begin
                mac_ctl.start = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (mac_done)
                begin
                    if (SW'(k_reg) + SW'(1) == k_eff) state_next = ST_EMIT;
                    else
                    begin
                        k_next = k_reg + KW'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_bits_next = oor_reg ? 32'd0 : acc_bits;
                    out_oor_next = oor_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        col_reg <= col_next;
        oor_reg <= oor_next;
        out_bits_reg <= out_bits_next;
        out_oor_reg <= out_oor_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.product_bits = out_bits_reg;
    assign out_ch.out_of_range = out_oor_reg;

    a_fetch_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |-> SW'(k_reg) < k_eff)
        else $error("inner index fetched beyond depth");

    a_done_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == ST_MAC)
        else $error("multiply-add finished outside its wait state");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result word raised outside emit");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (a_we || b_we) |=> state_reg == ST_IDLE)
        else $error("stored write did not return to idle");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_oor_reg) |-> out_bits_reg == 32'd0)
        else $error("out of range word carries data");

endmodule
